// ===== rtl/core/sat_pkg.sv =====
// shared types and constants for the summed area table query block
`timescale 1ns / 1ps

package sat_pkg;

   localparam int SUM_W     = 28;  // table entry and result width
   localparam int CFG_W     = 7;   // row / column count register width
   localparam int COORD_W   = 6;   // query corner width
   localparam int CSR_IDX_W = 1;   // register index width

   // item command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;

   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic [CFG_W-1:0]        count_type;
   typedef logic [COORD_W-1:0]      coord_type;

endpackage

// ===== rtl/core/sat_req_if.sv =====
// request channel: load and query items
`timescale 1ns / 1ps

interface sat_req_if
   import sat_pkg::*;
#(
   parameter int VALUE_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic signed [VALUE_WIDTH-1:0] element_value;
   coord_type                     top_row;
   coord_type                     left_col;
   coord_type                     bottom_row;
   coord_type                     right_col;

   modport source (
      output valid, cmd, element_value, top_row, left_col, bottom_row, right_col,
      input  ready
   );
   modport sink (
      input  valid, cmd, element_value, top_row, left_col, bottom_row, right_col,
      output ready
   );
endinterface

// ===== rtl/core/sat_rsp_if.sv =====
// response channel: rectangle sum items
`timescale 1ns / 1ps

interface sat_rsp_if
   import sat_pkg::*;
;
   logic    valid;
   logic    ready;
   sum_type rect_sum;
   logic    query_error;

   modport source (
      output valid, rect_sum, query_error,
      input  ready
   );
   modport sink (
      input  valid, rect_sum, query_error,
      output ready
   );
endinterface

// ===== rtl/core/summed_area_table_query.sv =====
// summed area table: raster load of a matrix and rectangle sum queries
`timescale 1ns / 1ps

// Loads a rows_in_use x cols_in_use matrix one element per load item in
// raster order and keeps its two-dimensional prefix sums in a single-port
// table memory of MAX_ROWS*MAX_COLS entries, 28 bits each, wrapping. A
// query item returns the sum of the inclusive rectangle between its two
// corners; it is flagged with query_error and a zero sum when the corners
// are out of order, fall outside the configured size, or the table is not
// fully loaded. A load item reads the upper neighbor while idle and
// writes the new entry in the next cycle. A good query steps through
// four corner reads through the one memory port, then a drain step, and
// loads the result register from the final state: a shared add/subtract
// accumulator takes each registered read in the step after it; a rejected
// query skips the reads and goes straight to the final state, where its
// zero result is registered. The result waits in an output register,
// so load items keep flowing while it is pending; a later query holds in
// its final cycle until the previous result is taken. A register write
// restarts loading at the first element. Table contents need no clearing
// after reset, since queries only run on a fully loaded table.

module summed_area_table_query
   import sat_pkg::*;
#(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 64,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   sat_req_if.sink              req_chan,
   sat_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int MUL_W  = ADDR_W + CFG_W;
   localparam int EXT_W  = (VALUE_WIDTH > SUM_W) ? VALUE_WIDTH : SUM_W;
   localparam logic [CFG_W-1:0] ROWS_RST = CFG_W'((MAX_ROWS < 64) ? MAX_ROWS : 64);
   localparam logic [CFG_W-1:0] COLS_RST = CFG_W'((MAX_COLS < 64) ? MAX_COLS : 64);
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_LAST = 3'd4;  // drain step, no read

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOAD_WR,
      S_QUERY,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   count_type         rows_ff, rows_in;
   count_type         cols_ff, cols_in;
   count_type         load_row_ff, load_row_in;
   count_type         load_col_ff, load_col_in;
   sum_type           run_ff, run_in;
   logic              ready_ff, ready_in;
   coord_type         q_top_ff, q_top_in;
   coord_type         q_left_ff, q_left_in;
   coord_type         q_bottom_ff, q_bottom_in;
   coord_type         q_right_ff, q_right_in;
   logic              q_err_ff, q_err_in;
   sum_type           acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sum_type           rsp_sum_ff, rsp_sum_in;
   logic              rsp_err_ff, rsp_err_in;

   // table memory
   sum_type           table_mem [DEPTH];
   sum_type           rd_data_ff;
   logic              mem_we;
   sum_type           mem_wdata;
   count_type         mem_row;
   count_type         mem_col;
   logic [MUL_W-1:0]  addr_wide;
   logic [ADDR_W-1:0] mem_addr;

   logic                 req_take;
   logic                 rsp_take;
   logic signed [EXT_W-1:0] elem_wide;
   sum_type              elem_ext;
   logic [1:0]           prev_step;
   logic                 term_use;
   logic                 term_sub;
   count_type            col_next;
   count_type            row_next;
   count_type            csr_clamped;
   count_type            csr_max;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_take       = rsp_valid_ff && rsp_chan.ready;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.rect_sum    = rsp_sum_ff;
   assign rsp_chan.query_error = rsp_err_ff;

   // element sign-extended (or wrapped) to the table width
   assign elem_wide = EXT_W'(signed'(req_chan.element_value[VALUE_WIDTH-1:0]));
   assign elem_ext  = elem_wide[SUM_W-1:0];

   // linear table address
   assign addr_wide = MUL_W'(mem_row) * MUL_W'(MAX_COLS) + MUL_W'(mem_col);
   assign mem_addr  = addr_wide[ADDR_W-1:0];

   // corner term whose read data is arriving this cycle
   assign prev_step = 2'(step_ff - 3'd1);
   always_comb begin
      term_use = 1'b1;
      term_sub = 1'b0;
      case (prev_step)
         2'd0: begin
            term_use = 1'b1;
            term_sub = 1'b0;
         end
         2'd1: begin
            term_use = (q_top_ff != '0);
            term_sub = 1'b1;
         end
         2'd2: begin
            term_use = (q_left_ff != '0);
            term_sub = 1'b1;
         end
         2'd3: begin
            term_use = (q_top_ff != '0) && (q_left_ff != '0);
            term_sub = 1'b0;
         end
         default: begin
            term_use = 1'b0;
            term_sub = 1'b0;
         end
      endcase
   end

   assign col_next = load_col_ff + 1'b1;
   assign row_next = load_row_ff + 1'b1;

   // register write value saturated to 1..max
   assign csr_max = (csr_index == CSR_ROWS) ? CFG_W'(MAX_ROWS) : CFG_W'(MAX_COLS);
   always_comb begin
      if (csr_wdata == '0) begin
         csr_clamped = CFG_W'(1);
      end else if (32'(csr_wdata) > ((csr_index == CSR_ROWS) ? 32'(MAX_ROWS)
                                                             : 32'(MAX_COLS))) begin
         csr_clamped = csr_max;
      end else begin
         csr_clamped = csr_wdata;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      load_row_in  = load_row_ff;
      load_col_in  = load_col_ff;
      run_in       = run_ff;
      ready_in     = ready_ff;
      q_top_in     = q_top_ff;
      q_left_in    = q_left_ff;
      q_bottom_in  = q_bottom_ff;
      q_right_in   = q_right_ff;
      q_err_in     = q_err_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_sum_in   = rsp_sum_ff;
      rsp_err_in   = rsp_err_ff;
      mem_we       = 1'b0;
      mem_wdata    = '0;
      mem_row      = '0;
      mem_col      = '0;

      case (state_ff)
         S_IDLE: begin
            // prefetch the entry above the next load position
            mem_row = (load_row_ff != '0) ? CFG_W'(load_row_ff - 1'b1) : '0;
            mem_col = load_col_ff;
            if (req_take) begin
               if (req_chan.cmd == CMD_LOAD) begin
                  run_in   = run_ff + elem_ext;
                  ready_in = 1'b0;  // a load after a full table starts a new one
                  state_in = S_LOAD_WR;
               end else begin
                  q_top_in    = req_chan.top_row;
                  q_left_in   = req_chan.left_col;
                  q_bottom_in = req_chan.bottom_row;
                  q_right_in  = req_chan.right_col;
                  q_err_in    = !ready_ff
                             || (req_chan.top_row > req_chan.bottom_row)
                             || (req_chan.left_col > req_chan.right_col)
                             || (CFG_W'(req_chan.bottom_row) >= rows_ff)
                             || (CFG_W'(req_chan.right_col) >= cols_ff);
                  acc_in      = '0;
                  step_in     = '0;
                  state_in    = S_QUERY;
               end
            end
         end

         S_LOAD_WR: begin
            mem_row   = load_row_ff;
            mem_col   = load_col_ff;
            mem_we    = 1'b1;
            mem_wdata = ((load_row_ff != '0) ? rd_data_ff : '0) + run_ff;
            if (col_next >= cols_ff) begin
               load_col_in = '0;
               run_in      = '0;
               if (row_next >= rows_ff) begin
                  load_row_in = '0;
                  ready_in    = 1'b1;
               end else begin
                  load_row_in = row_next;
               end
            end else begin
               load_col_in = col_next;
            end
            state_in = S_IDLE;
         end

         S_QUERY: begin
            // corner read for this step
            case (step_ff)
               3'd0: begin
                  mem_row = CFG_W'(q_bottom_ff);
                  mem_col = CFG_W'(q_right_ff);
               end
               3'd1: begin
                  mem_row = (q_top_ff != '0) ? CFG_W'(q_top_ff - 1'b1) : '0;
                  mem_col = CFG_W'(q_right_ff);
               end
               3'd2: begin
                  mem_row = CFG_W'(q_bottom_ff);
                  mem_col = (q_left_ff != '0) ? CFG_W'(q_left_ff - 1'b1) : '0;
               end
               3'd3: begin
                  mem_row = (q_top_ff != '0) ? CFG_W'(q_top_ff - 1'b1) : '0;
                  mem_col = (q_left_ff != '0) ? CFG_W'(q_left_ff - 1'b1) : '0;
               end
               default: begin
                  mem_row = '0;
                  mem_col = '0;
               end
            endcase
            if (q_err_ff) begin
               state_in = S_DONE;
            end else begin
               // shared accumulator takes the previous step's read
               if ((step_ff != '0) && term_use) begin
                  acc_in = term_sub ? (acc_ff - rd_data_ff) : (acc_ff + rd_data_ff);
               end
               if (step_ff == STEP_LAST) begin
                  state_in = S_DONE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff;  // still zero for a rejected query
               rsp_err_in   = q_err_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register write restarts loading
      if (csr_we) begin
         if (csr_index == CSR_ROWS) begin
            rows_in = csr_clamped;
         end else begin
            cols_in = csr_clamped;
         end
         load_row_in = '0;
         load_col_in = '0;
         run_in      = '0;
         ready_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rows_ff      <= ROWS_RST;
         cols_ff      <= COLS_RST;
         load_row_ff  <= '0;
         load_col_ff  <= '0;
         run_ff       <= '0;
         ready_ff     <= 1'b0;
         q_err_ff     <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         load_row_ff  <= load_row_in;
         load_col_ff  <= load_col_in;
         run_ff       <= run_in;
         ready_ff     <= ready_in;
         q_err_ff     <= q_err_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      q_top_ff    <= q_top_in;
      q_left_ff   <= q_left_in;
      q_bottom_ff <= q_bottom_in;
      q_right_ff  <= q_right_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_err_ff  <= rsp_err_in;
   end

   // single-port table, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[mem_addr];
   end

   // rejected queries always report a zero sum
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.query_error |-> rsp_chan.rect_sum == '0)
      else $error("rejected query with nonzero sum");

   // a new result only appears from the final query cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside query completion");

   // the table is written only in the load write cycle
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_LOAD_WR) && !req_chan.ready)
      else $error("table write outside load");

   // a load item always leads to its write cycle
   assert property (@(posedge clock) disable iff (reset)
      req_take && (req_chan.cmd == CMD_LOAD) && !csr_we |=> state_ff == S_LOAD_WR)
      else $error("load item did not reach write cycle");

endmodule
